// File: rtl/dvrt_pkg.sv
// Package for the distance-vector route table: table depths, opcodes, status codes,
// route kinds, controller states and the command/status structs. No dependencies.
package dvrt_pkg;

	// table depths; port widths are sized for these
	localparam int ROUTE_DEPTH = 64;
	localparam int IFACE_DEPTH = 8;

	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_TICK   = 3'd1;
	localparam logic [2:0] OP_ADDIF  = 3'd2;
	localparam logic [2:0] OP_IFDOWN = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_RT_FULL  = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;
	localparam logic [1:0] ST_IF_FULL  = 2'd3;

	localparam logic [1:0] KIND_LEARNED = 2'd0;
	localparam logic [1:0] KIND_UP      = 2'd1;
	localparam logic [1:0] KIND_DOWN    = 2'd2;

	localparam logic [1:0] CFG_UNREACH = 2'd0;
	localparam logic [1:0] CFG_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_STALE   = 2'd2;

	// one route entry as stored
	typedef struct packed {
		logic [31:0] net;
		logic [5:0]  prefix;
		logic [7:0]  distance;
		logic [31:0] hop;
		logic [1:0]  kind;
		logic [7:0]  age;
	} route_t;

	typedef struct packed {
		logic [31:0] own;
		logic [31:0] net;
		logic [7:0]  distance;
	} iface_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_IF_RD,    // read interface slot
		S_IF_CHK,   // compare interface slot
		S_RT_RD,    // read route slot
		S_RT_CHK,   // compare route slot
		S_TK_RD,    // tick: read slot
		S_TK_CHK,   // tick: age and judge slot
		S_TK_LAST,  // tick: read last entry for swap
		S_TK_MOVE,  // tick: write last entry into slot
		S_RD_WAIT,  // read entry: memory latency
		S_OUT       // result held
	} state_t;

	// controller commands
	typedef struct packed {
		logic       latch_in;    // input beat taken, keep its fields
		logic       clear_idx;   // scan index to zero
		logic       inc_idx;     // scan index plus one
		logic       rt_rd_last;  // read route at total-1
		logic       rt_rd_user;  // read route at entry_index
		logic       latch_if;    // keep the matched interface
		logic       latch_slot;  // keep the found slot
		logic       own_revive;  // own-sender revive at found slot
		logic       upd_found;   // update existing route if the metric wins or its own hop reports
		logic       append_rt;   // append learned route
		logic       add_iface;   // append interface and direct route
		logic       if_down;     // mark found slot down if it is up
		logic       tk_write;    // write aged slot back
		logic       tk_move;     // write last entry into slot, total-1
		logic       latch_read;  // latch read data into result
		logic       set_status;
		logic [1:0] status;
	} cmd_t;

	// datapath status
	typedef struct packed {
		logic if_end;     // scan index reached iface total
		logic rt_end;     // scan index reached route total
		logic if_match;   // interface own address equals sender
		logic rt_match;   // route net equals request net
		logic own_net;    // latched iface net equals request net
		logic if_full;
		logic rt_full;
		logic tk_delete;  // aged entry should be deleted
		logic read_ok;    // entry_index below total
	} stat_t;

endpackage

// File: rtl/dvrt_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/dvrt_datapath.sv
// Datapath of the route table: route and interface memories, totals,
// scan index, config registers, request and result registers. Uses dvrt_pkg, dvrt_ram.
module dvrt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [7:0]          cfg_data,
	input  logic [31:0]         peer_addr,
	input  logic [31:0]         dest_net,
	input  logic [5:0]          prefix_len,
	input  logic [31:0]         metric,
	input  logic [5:0]          entry_index,
	input  dvrt_pkg::cmd_t      cmd,
	output dvrt_pkg::stat_t     stat,
	output logic [1:0]          status,
	output logic [31:0]         route_net,
	output logic [5:0]          route_prefix,
	output logic [7:0]          route_distance,
	output logic [1:0]          route_kind,
	output logic [31:0]         route_next_hop,
	output logic [6:0]          route_count
);
	localparam int RA = $clog2(dvrt_pkg::ROUTE_DEPTH);
	localparam int IA = $clog2(dvrt_pkg::IFACE_DEPTH);
	localparam int RC = $clog2(dvrt_pkg::ROUTE_DEPTH + 1);
	localparam int IC = $clog2(dvrt_pkg::IFACE_DEPTH + 1);
	localparam int SC = (RC > IC) ? RC : IC;

	logic [7:0] unreach_q, limit_q, stale_q;
	logic [RC-1:0] rtot_q;
	logic [IC-1:0] itot_q;
	logic [SC-1:0] idx_q;
	logic [RA-1:0] slot_q;
	dvrt_pkg::iface_t ifm_q;

	// request fields, held for the whole operation
	logic [31:0] peer_q, net_q, met_q;
	logic [5:0]  pfx_q, eidx_q;
	logic [31:0] peer, net, met;
	logic [5:0]  pfx, eidx;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			peer_q <= peer_addr;
			net_q  <= dest_net;
			pfx_q  <= prefix_len;
			met_q  <= metric;
			eidx_q <= entry_index;
		end
	end
	assign peer = cmd.latch_in ? peer_addr : peer_q;
	assign net  = cmd.latch_in ? dest_net : net_q;
	assign pfx  = cmd.latch_in ? prefix_len : pfx_q;
	assign met  = cmd.latch_in ? metric : met_q;
	assign eidx = cmd.latch_in ? entry_index : eidx_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unreach_q <= 8'd16;
			limit_q   <= 8'd15;
			stale_q   <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dvrt_pkg::CFG_UNREACH: unreach_q <= cfg_data;
				dvrt_pkg::CFG_LIMIT:   limit_q   <= cfg_data;
				dvrt_pkg::CFG_STALE:   stale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp of the raw metric
	logic [7:0] clamped;
	assign clamped = (met > {24'd0, limit_q}) ? unreach_q : met[7:0];
	logic [7:0] if_clamped;
	assign if_clamped = (ifm_q.distance > limit_q) ? unreach_q : ifm_q.distance;

	// memories
	logic iwe;
	dvrt_pkg::iface_t iwd, ird;
	logic [IA-1:0] iraddr;
	assign iwe = cmd.add_iface;
	assign iwd = '{own: peer, net: net, distance: clamped};
	assign iraddr = idx_q[IA-1:0];

	dvrt_ram #(.WIDTH($bits(dvrt_pkg::iface_t)), .DEPTH(dvrt_pkg::IFACE_DEPTH)) u_iram (
		.clk(clk), .we(iwe), .waddr(itot_q[IA-1:0]), .wdata(iwd),
		.raddr(iraddr), .rdata(ird)
	);

	logic rwe;
	logic [RA-1:0] rwaddr, rraddr;
	dvrt_pkg::route_t rwd, rrd;

	always_comb begin
		if (cmd.rt_rd_last) rraddr = RA'(rtot_q - RC'(1));
		else if (cmd.rt_rd_user) rraddr = RA'(eidx);
		else rraddr = idx_q[RA-1:0];
	end

	// aged version of the entry under the tick scan
	logic [7:0] age_inc;
	logic stale;
	dvrt_pkg::route_t aged;
	assign age_inc = (rrd.age != 8'hFF) ? rrd.age + 8'd1 : rrd.age;
	assign stale = age_inc > stale_q;
	always_comb begin
		aged = rrd;
		aged.age = age_inc;
		if (stale) begin
			if (rrd.distance == unreach_q) begin
				// stale unreachable direct route: age one step back
				aged.age = age_inc - 8'd1;
			end else begin
				aged.age      = 8'd0;
				aged.distance = unreach_q;
				aged.hop      = 32'd0;
			end
		end
	end

	// update-found decision uses raw metric
	logic upd_skip, upd_take;
	assign upd_skip = (rrd.distance >= unreach_q) && (met >= {24'd0, unreach_q});
	assign upd_take = !upd_skip && (((rrd.hop == peer) &&
		(rrd.kind != dvrt_pkg::KIND_UP)) || ({24'd0, rrd.distance} >= met));

	// route write selection
	always_comb begin
		rwe = 1'b1;
		rwaddr = slot_q;
		rwd = rrd;
		if (cmd.own_revive) begin
			rwd.age = 8'd0;
			if (rrd.kind == dvrt_pkg::KIND_DOWN) begin
				rwd.kind     = dvrt_pkg::KIND_UP;
				rwd.distance = if_clamped;
				rwd.hop      = 32'd0;
			end
		end else if (cmd.upd_found) begin
			rwe = upd_take;
			rwd.age = 8'd0;
			rwd.distance = clamped;
			rwd.hop = peer;
		end else if (cmd.if_down) begin
			rwe = (rrd.kind == dvrt_pkg::KIND_UP);
			rwd.kind = dvrt_pkg::KIND_DOWN;
			rwd.age = 8'd0;
			rwd.distance = unreach_q;
			rwd.hop = 32'd0;
		end else if (cmd.append_rt || cmd.add_iface) begin
			rwaddr = RA'(rtot_q);
			rwd = '{net: net, prefix: pfx, distance: clamped,
				hop: cmd.add_iface ? 32'd0 : peer,
				kind: cmd.add_iface ? dvrt_pkg::KIND_UP : dvrt_pkg::KIND_LEARNED,
				age: 8'd0};
		end else if (cmd.tk_write) begin
			rwaddr = idx_q[RA-1:0];
			rwd = aged;
		end else if (cmd.tk_move) begin
			rwaddr = idx_q[RA-1:0];
			rwd = rrd;
		end else begin
			rwe = 1'b0;
		end
	end

	dvrt_ram #(.WIDTH($bits(dvrt_pkg::route_t)), .DEPTH(dvrt_pkg::ROUTE_DEPTH)) u_rram (
		.clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwd),
		.raddr(rraddr), .rdata(rrd)
	);

	// scan index, totals, latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			rtot_q <= '0;
			itot_q <= '0;
		end else begin
			if (cmd.clear_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + SC'(1);
			if (cmd.append_rt || cmd.add_iface) rtot_q <= rtot_q + RC'(1);
			else if (cmd.tk_move) rtot_q <= rtot_q - RC'(1);
			if (cmd.add_iface) itot_q <= itot_q + IC'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_if) ifm_q <= ird;
		if (cmd.latch_slot) slot_q <= idx_q[RA-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status <= dvrt_pkg::ST_DONE;
			route_net <= '0; route_prefix <= '0; route_distance <= '0;
			route_kind <= '0; route_next_hop <= '0;
		end else if (cmd.set_status) begin
			status <= cmd.status;
			route_net <= '0; route_prefix <= '0; route_distance <= '0;
			route_kind <= '0; route_next_hop <= '0;
			if (cmd.latch_read) begin
				route_net <= rrd.net; route_prefix <= rrd.prefix;
				route_distance <= rrd.distance; route_kind <= rrd.kind;
				route_next_hop <= rrd.hop;
			end
		end
	end
	assign route_count = 7'(rtot_q);

	assign stat.if_end   = SC'(itot_q) <= idx_q;
	assign stat.rt_end   = SC'(rtot_q) <= idx_q;
	assign stat.if_match = ird.own == peer;
	assign stat.rt_match = rrd.net == net;
	assign stat.own_net  = ifm_q.net == net;
	assign stat.if_full  = itot_q >= IC'(dvrt_pkg::IFACE_DEPTH);
	assign stat.rt_full  = rtot_q >= RC'(dvrt_pkg::ROUTE_DEPTH);
	assign stat.tk_delete = stale && (rrd.distance == unreach_q) &&
		(rrd.kind == dvrt_pkg::KIND_LEARNED);
	assign stat.read_ok  = RC'(eidx) < rtot_q;
endmodule

// File: rtl/dvrt_ctrl.sv
// Controller state machine of the route table: sequences the scans.
// Uses dvrt_pkg.
module dvrt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  logic [2:0]      opcode,
	input  dvrt_pkg::stat_t stat,
	output dvrt_pkg::cmd_t  cmd
);
	dvrt_pkg::state_t state_q, state_d;
	logic [2:0] op_q, op_d;
	logic own_q, own_d;   // own sender found, now looking for its route

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvrt_pkg::S_IDLE;
			op_q <= '0;
			own_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			own_q <= own_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		own_d = own_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			dvrt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d = opcode;
					own_d = 1'b0;
					cmd.latch_in = 1'b1;
					cmd.clear_idx = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status = dvrt_pkg::ST_DONE;
					unique case (opcode)
						dvrt_pkg::OP_UPDATE: state_d = dvrt_pkg::S_IF_RD;
						dvrt_pkg::OP_TICK:   state_d = dvrt_pkg::S_TK_RD;
						dvrt_pkg::OP_IFDOWN: state_d = dvrt_pkg::S_RT_RD;
						dvrt_pkg::OP_READ: begin
							cmd.rt_rd_user = 1'b1;
							state_d = dvrt_pkg::S_RD_WAIT;
						end
						dvrt_pkg::OP_ADDIF: begin
							state_d = dvrt_pkg::S_OUT;
							if (stat.if_full) cmd.status = dvrt_pkg::ST_IF_FULL;
							else if (stat.rt_full) cmd.status = dvrt_pkg::ST_RT_FULL;
							else cmd.add_iface = 1'b1;
						end
						default: state_d = dvrt_pkg::S_OUT;
					endcase
				end
			end
			dvrt_pkg::S_IF_RD: begin
				if (stat.if_end) begin
					cmd.clear_idx = 1'b1;
					state_d = dvrt_pkg::S_RT_RD;
				end else begin
					state_d = dvrt_pkg::S_IF_CHK;
				end
			end
			dvrt_pkg::S_IF_CHK: begin
				if (stat.if_match) begin
					cmd.latch_if = 1'b1;
					cmd.clear_idx = 1'b1;
					own_d = 1'b1;
					state_d = dvrt_pkg::S_RT_RD;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d = dvrt_pkg::S_IF_RD;
				end
			end
			dvrt_pkg::S_RT_RD: begin
				if (own_q && !stat.own_net) begin
					state_d = dvrt_pkg::S_OUT;
				end else if (stat.rt_end) begin
					state_d = dvrt_pkg::S_OUT;
					if (op_q == dvrt_pkg::OP_UPDATE && !own_q) begin
						if (stat.rt_full) begin
							cmd.set_status = 1'b1;
							cmd.status = dvrt_pkg::ST_RT_FULL;
						end else begin
							cmd.append_rt = 1'b1;
						end
					end
				end else begin
					cmd.latch_slot = 1'b1;
					state_d = dvrt_pkg::S_RT_CHK;
				end
			end
			dvrt_pkg::S_RT_CHK: begin
				if (!stat.rt_match) begin
					cmd.inc_idx = 1'b1;
					state_d = dvrt_pkg::S_RT_RD;
				end else begin
					// first route for the network decides
					state_d = dvrt_pkg::S_OUT;
					if (own_q) cmd.own_revive = 1'b1;
					else if (op_q == dvrt_pkg::OP_UPDATE) cmd.upd_found = 1'b1;
					else cmd.if_down = 1'b1;
				end
			end
			dvrt_pkg::S_TK_RD: begin
				if (stat.rt_end) state_d = dvrt_pkg::S_OUT;
				else state_d = dvrt_pkg::S_TK_CHK;
			end
			dvrt_pkg::S_TK_CHK: begin
				if (stat.tk_delete) begin
					cmd.rt_rd_last = 1'b1;
					state_d = dvrt_pkg::S_TK_LAST;
				end else begin
					cmd.tk_write = 1'b1;
					cmd.inc_idx = 1'b1;
					state_d = dvrt_pkg::S_TK_RD;
				end
			end
			dvrt_pkg::S_TK_LAST: begin
				cmd.rt_rd_last = 1'b1;
				state_d = dvrt_pkg::S_TK_MOVE;
			end
			dvrt_pkg::S_TK_MOVE: begin
				// last entry now in read data; examine same slot again
				cmd.tk_move = 1'b1;
				state_d = dvrt_pkg::S_TK_RD;
			end
			dvrt_pkg::S_RD_WAIT: begin
				cmd.set_status = 1'b1;
				if (stat.read_ok) begin
					cmd.latch_read = 1'b1;
					cmd.status = dvrt_pkg::ST_DONE;
				end else begin
					cmd.status = dvrt_pkg::ST_NO_ENTRY;
				end
				state_d = dvrt_pkg::S_OUT;
			end
			dvrt_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = dvrt_pkg::S_IDLE;
			end
			default: state_d = dvrt_pkg::S_IDLE;
		endcase
	end
endmodule

// File: rtl/distance_vector_route_table.sv
// Distance-vector route table, top level. Joins dvrt_ctrl and dvrt_datapath.
// Uses dvrt_pkg, dvrt_ram.
//
// One operation per input beat, one result beat per operation; the next input beat
// is taken only after the result beat, once the controller is back in idle. Each
// operation is sequenced by a controller over simple dual-port route and interface
// RAMs with registered read, with a read state and a check state for each slot
// scanned. An update scans the interfaces, then the routes; a tick scans the routes
// and moves the last entry into each deleted slot; interface down scans the routes;
// add interface goes straight to the result and read entry through a wait state.
// Table depths are fixed in dvrt_pkg. Route memory contents are undefined after
// reset; only data from slots below the count is ever used.
module distance_vector_route_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] peer_addr,
	input  logic [31:0] dest_net,
	input  logic [5:0]  prefix_len,
	input  logic [31:0] metric,
	input  logic [5:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] route_net,
	output logic [5:0]  route_prefix,
	output logic [7:0]  route_distance,
	output logic [1:0]  route_kind,
	output logic [31:0] route_next_hop,
	output logic [6:0]  route_count
);
	dvrt_pkg::cmd_t  cmd;
	dvrt_pkg::stat_t stat;

	dvrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .opcode(opcode),
		.stat(stat), .cmd(cmd)
	);

	dvrt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .peer_addr(peer_addr),
		.dest_net(dest_net), .prefix_len(prefix_len), .metric(metric),
		.entry_index(entry_index), .cmd(cmd), .stat(stat), .status(status),
		.route_net(route_net), .route_prefix(route_prefix),
		.route_distance(route_distance), .route_kind(route_kind),
		.route_next_hop(route_next_hop), .route_count(route_count)
	);
endmodule

// File: verif/distance_vector_route_table_tb.sv
// Testbench for distance_vector_route_table: directed and random operations, with
// result beats checked against an in-bench model of the route table. Uses dvrt_pkg.
`timescale 1ns / 1ps

module distance_vector_route_table_tb;

	localparam int RT_DEPTH = 64;
	localparam int IF_DEPTH = 8;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] net;
		logic [5:0]  prefix;
		logic [7:0]  distance;
		logic [1:0]  kind;
		logic [31:0] hop;
		logic [6:0]  count;
	} route_reply_t;

	// holds the table model and the replies it predicts
	class route_table_scoreboard;
		logic [31:0] r_net[RT_DEPTH];
		logic [5:0]  r_pfx[RT_DEPTH];
		logic [7:0]  r_dist[RT_DEPTH];
		logic [31:0] r_hop[RT_DEPTH];
		logic [1:0]  r_kind[RT_DEPTH];
		logic [7:0]  r_age[RT_DEPTH];
		int          r_total;
		logic [31:0] i_own[IF_DEPTH];
		logic [31:0] i_net[IF_DEPTH];
		logic [7:0]  i_dist[IF_DEPTH];
		int          i_total;
		logic [7:0]  unreach = 8'd16;
		logic [7:0]  dlimit = 8'd15;
		logic [7:0]  stale = 8'd5;
		route_reply_t pending_replies[$];
		int          errors;

		function logic [7:0] clamp(logic [31:0] d);
			return (d > {24'd0, dlimit}) ? unreach : d[7:0];
		endfunction

		function int find_net(logic [31:0] net);
			for (int i = 0; i < r_total; i++)
				if (r_net[i] == net) return i;
			return -1;
		endfunction

		function void refresh(int s, logic [31:0] d, logic [31:0] hop);
			r_age[s] = 0;
			r_dist[s] = clamp(d);
			r_hop[s] = hop;
		endfunction

		function void append(logic [31:0] net, logic [5:0] pfx, logic [7:0] d,
				logic [1:0] kind, logic [31:0] hop);
			r_net[r_total] = net;
			r_pfx[r_total] = pfx;
			r_dist[r_total] = d;
			r_kind[r_total] = kind;
			r_hop[r_total] = hop;
			r_age[r_total] = 0;
			r_total++;
		endfunction

		function logic [1:0] learn(logic [31:0] peer, logic [31:0] net, logic [5:0] pfx,
				logic [31:0] met);
			int s;
			for (int i = 0; i < i_total; i++) begin
				if (i_own[i] == peer) begin
					s = find_net(net);
					// own sender on own network brings the direct route back
					if (i_net[i] == net && s >= 0) begin
						r_age[s] = 0;
						if (r_kind[s] == dvrt_pkg::KIND_DOWN) begin
							r_kind[s] = dvrt_pkg::KIND_UP;
							refresh(s, {24'd0, i_dist[i]}, 32'd0);
						end
					end
					return dvrt_pkg::ST_DONE;
				end
			end
			s = find_net(net);
			if (s >= 0) begin
				if (r_dist[s] >= unreach && met >= {24'd0, unreach})
					return dvrt_pkg::ST_DONE;
				if ((r_hop[s] == peer && r_kind[s] != dvrt_pkg::KIND_UP) ||
						{24'd0, r_dist[s]} >= met)
					refresh(s, met, peer);
				return dvrt_pkg::ST_DONE;
			end
			if (r_total >= RT_DEPTH) return dvrt_pkg::ST_RT_FULL;
			append(net, pfx, clamp(met), dvrt_pkg::KIND_LEARNED, peer);
			return dvrt_pkg::ST_DONE;
		endfunction

		function void age_all();
			int i;
			int last;
			i = 0;
			while (i < r_total) begin
				if (r_age[i] < 8'd255) r_age[i]++;
				if (r_age[i] > stale) begin
					if (r_dist[i] == unreach) begin
						if (r_kind[i] != dvrt_pkg::KIND_LEARNED) begin
							r_age[i]--;
						end else begin
							// last entry moves in and is judged in this slot
							last = r_total - 1;
							r_net[i] = r_net[last];
							r_pfx[i] = r_pfx[last];
							r_dist[i] = r_dist[last];
							r_hop[i] = r_hop[last];
							r_kind[i] = r_kind[last];
							r_age[i] = r_age[last];
							r_total = last;
							continue;
						end
					end else begin
						refresh(i, {24'd0, unreach}, 32'd0);
					end
				end
				i++;
			end
		endfunction

		function void note_beat(logic [2:0] op, logic [31:0] peer, logic [31:0] net,
				logic [5:0] pfx, logic [31:0] met, logic [5:0] idx);
			route_reply_t r;
			int s;
			logic [7:0] d;
			r = '{default: '0};
			case (op)
				dvrt_pkg::OP_UPDATE: r.status = learn(peer, net, pfx, met);
				dvrt_pkg::OP_TICK: age_all();
				dvrt_pkg::OP_ADDIF: begin
					if (i_total >= IF_DEPTH) r.status = dvrt_pkg::ST_IF_FULL;
					else if (r_total >= RT_DEPTH) r.status = dvrt_pkg::ST_RT_FULL;
					else begin
						d = clamp(met);
						i_own[i_total] = peer;
						i_net[i_total] = net;
						i_dist[i_total] = d;
						i_total++;
						append(net, pfx, d, dvrt_pkg::KIND_UP, 32'd0);
					end
				end
				dvrt_pkg::OP_IFDOWN: begin
					s = find_net(net);
					if (s >= 0 && r_kind[s] == dvrt_pkg::KIND_UP) begin
						r_kind[s] = dvrt_pkg::KIND_DOWN;
						refresh(s, {24'd0, unreach}, 32'd0);
					end
				end
				dvrt_pkg::OP_READ: begin
					if (idx < r_total) begin
						r.net = r_net[idx];
						r.prefix = r_pfx[idx];
						r.distance = r_dist[idx];
						r.kind = r_kind[idx];
						r.hop = r_hop[idx];
					end else begin
						r.status = dvrt_pkg::ST_NO_ENTRY;
					end
				end
				default: ;
			endcase
			r.count = r_total[6:0];
			pending_replies.push_back(r);
		endfunction

		function void check_beat(route_reply_t a);
			route_reply_t e;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result beat with nothing pending");
				return;
			end
			e = pending_replies.pop_front();
			if (a.status !== e.status || a.net !== e.net || a.prefix !== e.prefix ||
					a.distance !== e.distance || a.kind !== e.kind || a.hop !== e.hop ||
					a.count !== e.count) begin
				errors++;
				if (errors <= 10) begin
					$display("exp st=%0d net=%h pfx=%0d d=%0d k=%0d hop=%h cnt=%0d",
						e.status, e.net, e.prefix, e.distance, e.kind, e.hop, e.count);
					$display("got st=%0d net=%h pfx=%0d d=%0d k=%0d hop=%h cnt=%0d",
						a.status, a.net, a.prefix, a.distance, a.kind, a.hop, a.count);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = '0;
	logic [31:0] peer_addr = '0;
	logic [31:0] dest_net = '0;
	logic [5:0]  prefix_len = '0;
	logic [31:0] metric = '0;
	logic [5:0]  entry_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] route_net;
	logic [5:0]  route_prefix;
	logic [7:0]  route_distance;
	logic [1:0]  route_kind;
	logic [31:0] route_next_hop;
	logic [6:0]  route_count;

	route_table_scoreboard sb = new();
	logic [31:0] net_pool[128];
	logic [31:0] peer_pool[12];
	logic [31:0] own_q[$];
	logic [31:0] own_net_q[$];
	bit          no_gaps;
	int          cycles = 0;

	distance_vector_route_table uut (.*);

	always #1 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("distance_vector_route_table: mismatch");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_beat('{status, route_net, route_prefix, route_distance,
				route_kind, route_next_hop, route_count});
	end

	// receiver stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_beat(logic [2:0] op, logic [31:0] peer, logic [31:0] net,
			logic [5:0] pfx, logic [31:0] met, logic [5:0] idx);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		peer_addr <= peer;
		dest_net <= net;
		prefix_len <= pfx;
		metric <= met;
		entry_index <= idx;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_beat(op, peer, net, pfx, met, idx);
		if (op == dvrt_pkg::OP_ADDIF) begin
			own_q.push_back(peer);
			own_net_q.push_back(net);
		end
	endtask

	// drain, then write all three registers
	task automatic set_regs(logic [7:0] unr, logic [7:0] lim, logic [7:0] stl);
		@(posedge clk);
		in_valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= dvrt_pkg::CFG_UNREACH;
		cfg_data <= unr;
		@(posedge clk);
		cfg_idx <= dvrt_pkg::CFG_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_idx <= dvrt_pkg::CFG_STALE;
		cfg_data <= stl;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.unreach = unr;
		sb.dlimit = lim;
		sb.stale = stl;
	endtask

	function automatic logic [31:0] pick_metric();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'($urandom_range(250, 260));
			default: return 32'($urandom_range(0, 20));
		endcase
	endfunction

	task automatic random_beats(int n, int net_span);
		int k;
		int sel;
		logic [31:0] peer;
		logic [31:0] net;
		for (int j = 0; j < n; j++) begin
			if (j % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			net = net_pool[$urandom_range(0, net_span - 1)];
			peer = peer_pool[$urandom_range(0, 11)];
			if (sel < 50) begin
				// own-address echo of an interface network now and then
				if (own_q.size() > 0 && $urandom_range(0, 7) == 0) begin
					k = $urandom_range(0, own_q.size() - 1);
					peer = own_q[k];
					net = own_net_q[k];
				end
				send_beat(dvrt_pkg::OP_UPDATE, peer, net, 6'($urandom_range(0, 32)),
					pick_metric(), 6'($urandom()));
			end else if (sel < 65) begin
				send_beat(dvrt_pkg::OP_TICK, $urandom(), $urandom(), 6'($urandom()),
					$urandom(), 6'($urandom()));
			end else if (sel < 69) begin
				send_beat(dvrt_pkg::OP_ADDIF, peer, net, 6'($urandom_range(0, 32)),
					pick_metric(), 6'($urandom()));
			end else if (sel < 77) begin
				if (own_net_q.size() > 0 && $urandom_range(0, 1))
					net = own_net_q[$urandom_range(0, own_net_q.size() - 1)];
				send_beat(dvrt_pkg::OP_IFDOWN, $urandom(), net, 6'($urandom()),
					$urandom(), 6'($urandom()));
			end else if (sel < 96) begin
				send_beat(dvrt_pkg::OP_READ, $urandom(), $urandom(), 6'($urandom()),
					$urandom(), 6'($urandom_range(0, 63)));
			end else begin
				// unused opcodes
				send_beat(3'($urandom_range(5, 7)), $urandom(), $urandom(),
					6'($urandom()), $urandom(), 6'($urandom()));
			end
		end
	endtask

	initial begin
		no_gaps = 1'b0;
		for (int i = 0; i < 128; i++) net_pool[i] = $urandom();
		net_pool[0] = 32'h0;
		net_pool[1] = 32'hFFFF_FFFF;
		for (int i = 0; i < 12; i++) peer_pool[i] = $urandom();
		peer_pool[0] = 32'hFFFF_FFFF;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: interfaces, own-sender revive, learn, refresh, aging
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_ADDIF, 32'hFFFF_FFFF, 32'h0, 6'd32, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_ADDIF, 32'h0A00_0001, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF,
			6'd0);
		send_beat(dvrt_pkg::OP_IFDOWN, 32'd0, 32'h0, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_IFDOWN, 32'd0, 32'h1234_5678, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'h0, 6'd32, 32'd7, 6'd0);
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0005, 32'hC0A8_0000, 6'd24, 32'd4, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0006, 32'hC0A8_0000, 6'd24, 32'd2, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0005, 32'hC0A8_0000, 6'd24, 32'd9, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0006, 32'hC0A8_0000, 6'd24, 32'hFFFF_FFFF,
			6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0007, 32'hC0A8_0000, 6'd24, 32'd16, 6'd0);
		send_beat(dvrt_pkg::OP_UPDATE, 32'h0000_0008, 32'h0A0A_0000, 6'd16, 32'd200, 6'd0);
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd2);
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd63);
		for (int i = 0; i < 7; i++)
			send_beat(dvrt_pkg::OP_TICK, 32'd0, 32'd0, 6'd0, 32'd0, 6'd0);
		send_beat(dvrt_pkg::OP_READ, 32'd0, 32'd0, 6'd0, 32'd0, 6'd1);
		send_beat(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63);

		// random phases under several register settings
		set_regs(8'd255, 8'd254, 8'd254);
		random_beats(300, 100);
		set_regs(8'd1, 8'd0, 8'd0);
		random_beats(200, 16);
		set_regs(8'd16, 8'd15, 8'd3);
		random_beats(200, 24);
		set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 254)),
			8'($urandom_range(0, 254)));
		random_beats(200, 40);

		// drain and let the block settle
		@(posedge clk);
		in_valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending_replies.size() == 0)
			$display("distance_vector_route_table: match");
		else
			$display("distance_vector_route_table: mismatch");
		$finish;
	end

endmodule
